/* rtl/core/mis_pkg.sv */
// ----------------------------------------------------------------------------
// mis_pkg - shared types and constants of the multithread issue scheduler
// Field widths, operation and action codes, register map and reset values.
// ----------------------------------------------------------------------------
package mis_pkg;

    // transaction field widths
    localparam int OP_W  = 2;
    localparam int ACT_W = 2;
    localparam int TID_W = 3;
    localparam int ADD_W = 9;
    localparam int CYC_W = 48;
    localparam int INS_W = 40;
    localparam int PC_W  = 32;
    localparam int LAT_W = 8;
    localparam int TC_W  = 4;

    // instruction kind at the front thread
    typedef enum logic [OP_W-1:0] {
        OP_OTHER = 2'd0,
        OP_LOAD  = 2'd1,
        OP_STORE = 2'd2,
        OP_HALT  = 2'd3
    } t_op;

    // what a step did
    typedef enum logic [ACT_W-1:0] {
        ACT_IDLE   = 2'd0,
        ACT_SKIP   = 2'd1,
        ACT_ISSUE  = 2'd2,
        ACT_HALTED = 2'd3
    } t_action;

    // APB register map (word index = paddr[4:2])
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_POLICY       = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_THREAD_COUNT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LOAD_LAT     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_STORE_LAT    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SWITCH_PEN   = 3'd4;

    // register reset values
    localparam logic             RST_POLICY       = 1'b0;
    localparam logic [TC_W-1:0]  RST_THREAD_COUNT = 4'd2;
    localparam logic [LAT_W-1:0] RST_LOAD_LAT     = 8'd4;
    localparam logic [LAT_W-1:0] RST_STORE_LAT    = 8'd1;
    localparam logic [LAT_W-1:0] RST_SWITCH_PEN   = 8'd2;

    // saturation limits of the running totals
    localparam logic [CYC_W-1:0] CYC_MAX = {CYC_W{1'b1}};
    localparam logic [INS_W-1:0] INS_MAX = {INS_W{1'b1}};

endpackage

/* rtl/core/mis_ifs.sv */
// ----------------------------------------------------------------------------
// mis_ifs - valid/ready channel interfaces of the multithread issue scheduler
// Step channel (instruction kind in) and result channel (step outcome out).
// ----------------------------------------------------------------------------
interface mis_step_if;
    logic                      valid;
    logic                      ready;
    logic [mis_pkg::OP_W-1:0]  op_kind;

    modport source (output valid, output op_kind, input ready);
    modport sink   (input valid, input op_kind, output ready);
endinterface

interface mis_result_if;
    logic                       valid;
    logic                       ready;
    logic [mis_pkg::ACT_W-1:0]  action;
    logic [mis_pkg::TID_W-1:0]  issued_thread;
    logic [mis_pkg::ADD_W-1:0]  cycles_added;
    logic [mis_pkg::CYC_W-1:0]  total_cycles;
    logic [mis_pkg::INS_W-1:0]  total_instructions;
    logic [mis_pkg::TID_W-1:0]  next_thread;
    logic [mis_pkg::PC_W-1:0]   next_pc;

    modport source (output valid, output action, output issued_thread, output cycles_added,
                    output total_cycles, output total_instructions, output next_thread,
                    output next_pc, input ready);
    modport sink   (input valid, input action, input issued_thread, input cycles_added,
                    input total_cycles, input total_instructions, input next_thread,
                    input next_pc, output ready);
endinterface

/* rtl/core/multithread_issue_scheduler.sv */
// ----------------------------------------------------------------------------
// multithread_issue_scheduler - blocked / fine-grained multithreading scheduler
// Decides, one step per transaction, whether the front thread issues, is
// skipped while it waits on memory, or the core idles, or all threads have
// halted; keeps cycle and instruction totals.
// ----------------------------------------------------------------------------
// Each step transaction carries the instruction kind found at the front
// thread's program counter and yields exactly one result transaction: the
// action taken, the thread that issued, the cycles charged (switch penalty
// included), the saturating cycle and instruction totals, and the front thread
// and program counter that the next step describes. The block takes one step
// per clock cycle, back to back, as long as the result sink takes each result.
// A step is caught in the input register at the edge that accepts it, and its
// result is loaded into the result register when that register is free or being
// drained. That rate rests on the scheduler state update - wait counters,
// halted mask, program counters and front pointer - which is combinational
// logic between the two registers. A full result register with a stalled sink
// still lets one more step be held in the input register. Configuration is via
// APB (word registers at 0x00 policy, 0x04 thread_count, 0x08 load_latency,
// 0x0C store_latency, 0x10 switch_penalty) and is to be written only while no
// step is in flight.
// ----------------------------------------------------------------------------
module multithread_issue_scheduler #(
    parameter int MAX_THREADS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    mis_step_if.sink                      i_step,
    mis_result_if.source                  o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mis_pkg::APB_AW-1:0]    paddr,
    input  logic [mis_pkg::APB_DW-1:0]    pwdata,
    output logic [mis_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    // thread index width and thread count width
    localparam int TW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
    localparam int CW = $clog2(MAX_THREADS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_THREADS);

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------

    // first live thread at or after start, cyclically; start if none live.
    // start is always below the active count and live is masked by it.
    function automatic logic [TW-1:0] live_from(input logic [TW-1:0]          start,
                                                input logic [MAX_THREADS-1:0] live);
        logic [MAX_THREADS-1:0] hi;
        logic [TW-1:0]          res;
        logic                   found;
        res   = start;
        found = 1'b0;
        for (int t = 0; t < MAX_THREADS; t++) begin
            hi[t] = live[t] && (TW'(t) >= start);
        end
        for (int t = 0; t < MAX_THREADS; t++) begin
            if (!found && hi[t]) begin
                res   = TW'(t);
                found = 1'b1;
            end
        end
        for (int t = 0; t < MAX_THREADS; t++) begin
            if (!found && live[t]) begin
                res   = TW'(t);
                found = 1'b1;
            end
        end
        return res;
    endfunction

    // thread index onto the 3-bit result fields
    function automatic logic [mis_pkg::TID_W-1:0] to_tid(input logic [TW-1:0] x);
        logic [TW+mis_pkg::TID_W-1:0] x_ext;
        x_ext = {{mis_pkg::TID_W{1'b0}}, x};
        return x_ext[mis_pkg::TID_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // APB configuration registers
    // ------------------------------------------------------------------
    logic                            r_policy;
    logic [mis_pkg::TC_W-1:0]        r_thread_count;
    logic [mis_pkg::LAT_W-1:0]       r_load_lat;
    logic [mis_pkg::LAT_W-1:0]       r_store_lat;
    logic [mis_pkg::LAT_W-1:0]       r_switch_pen;

    logic                            cfg_wr;
    logic [mis_pkg::REG_IDX_W-1:0]   cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[mis_pkg::APB_AW-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy       <= mis_pkg::RST_POLICY;
            r_thread_count <= mis_pkg::RST_THREAD_COUNT;
            r_load_lat     <= mis_pkg::RST_LOAD_LAT;
            r_store_lat    <= mis_pkg::RST_STORE_LAT;
            r_switch_pen   <= mis_pkg::RST_SWITCH_PEN;
        end else if (cfg_wr) begin
            case (cfg_idx)
                mis_pkg::REG_POLICY:       r_policy       <= pwdata[0];
                mis_pkg::REG_THREAD_COUNT: r_thread_count <= pwdata[mis_pkg::TC_W-1:0];
                mis_pkg::REG_LOAD_LAT:     r_load_lat     <= pwdata[mis_pkg::LAT_W-1:0];
                mis_pkg::REG_STORE_LAT:    r_store_lat    <= pwdata[mis_pkg::LAT_W-1:0];
                mis_pkg::REG_SWITCH_PEN:   r_switch_pen   <= pwdata[mis_pkg::LAT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            mis_pkg::REG_POLICY:       prdata = {{(mis_pkg::APB_DW-1){1'b0}}, r_policy};
            mis_pkg::REG_THREAD_COUNT: prdata = {{(mis_pkg::APB_DW-mis_pkg::TC_W){1'b0}},
                                                 r_thread_count};
            mis_pkg::REG_LOAD_LAT:     prdata = {{(mis_pkg::APB_DW-mis_pkg::LAT_W){1'b0}},
                                                 r_load_lat};
            mis_pkg::REG_STORE_LAT:    prdata = {{(mis_pkg::APB_DW-mis_pkg::LAT_W){1'b0}},
                                                 r_store_lat};
            mis_pkg::REG_SWITCH_PEN:   prdata = {{(mis_pkg::APB_DW-mis_pkg::LAT_W){1'b0}},
                                                 r_switch_pen};
            default:                   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // input register / result register handshake
    // ------------------------------------------------------------------
    logic                            r_in_valid;
    logic [mis_pkg::OP_W-1:0]        r_in_op;
    logic                            r_out_valid;
    logic                            step_go;

    // a step is evaluated when the result register is free or being drained
    assign step_go      = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_step.ready = !r_in_valid || step_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_step.ready) begin
                r_in_valid <= i_step.valid;
            end
            if (step_go) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step.valid && i_step.ready) begin
            r_in_op <= i_step.op_kind;
        end
    end

    // ------------------------------------------------------------------
    // scheduler state
    // ------------------------------------------------------------------
    logic [mis_pkg::LAT_W-1:0]  r_wait [MAX_THREADS];
    logic [mis_pkg::PC_W-1:0]   r_pc   [MAX_THREADS];
    logic [MAX_THREADS-1:0]     r_halted;
    logic [TW-1:0]              r_front;
    logic [TW-1:0]              r_last;
    logic [mis_pkg::CYC_W-1:0]  r_cyc;
    logic [mis_pkg::INS_W-1:0]  r_ins;

    logic [mis_pkg::LAT_W-1:0]  n_wait [MAX_THREADS];
    logic [mis_pkg::PC_W-1:0]   n_pc   [MAX_THREADS];
    logic [MAX_THREADS-1:0]     n_halted;
    logic [TW-1:0]              n_front;
    logic [TW-1:0]              n_last;
    logic [mis_pkg::CYC_W-1:0]  n_cyc;
    logic [mis_pkg::INS_W-1:0]  n_ins;

    // step evaluation
    mis_pkg::t_op               op;
    mis_pkg::t_action           act;
    logic [CW-1:0]              cnt;
    logic [CW-1:0]              succ_cnt;
    logic [MAX_THREADS-1:0]     in_range;
    logic [MAX_THREADS-1:0]     live;
    logic [MAX_THREADS-1:0]     live_new;
    logic [MAX_THREADS-1:0]     thr_ready;
    logic [MAX_THREADS-1:0]     other_rdy;
    logic [MAX_THREADS-1:0]     rot_mask;
    logic                       all_halted;
    logic                       is_idle;
    logic                       is_skip;
    logic                       is_issue;
    logic                       rotate;
    logic                       pen_on;
    logic [TW-1:0]              start0;
    logic [TW-1:0]              front0;
    logic [TW-1:0]              succ;
    logic [TW-1:0]              rot_front;
    logic [mis_pkg::ADD_W-1:0]  pen1;
    logic [mis_pkg::ADD_W-1:0]  added;
    logic [mis_pkg::CYC_W:0]    cyc_sum;
    logic [mis_pkg::PC_W-1:0]   next_pc;

    always_comb begin
        op = mis_pkg::t_op'(r_in_op);

        // active thread count: zero acts as one, clamp at the thread limit
        if (r_thread_count == '0) begin
            cnt = CW'(1);
        end else if ({1'b0, r_thread_count} > (mis_pkg::TC_W+1)'(MAX_THREADS)) begin
            cnt = CNT_MAX;
        end else begin
            cnt = CW'(r_thread_count);
        end

        for (int t = 0; t < MAX_THREADS; t++) begin
            in_range[t]  = CW'(t) < cnt;
            live[t]      = in_range[t] && !r_halted[t];
            thr_ready[t] = live[t] && (r_wait[t] == '0);
        end
        all_halted = (live == '0);

        // normalise the front onto a live thread
        start0 = (CW'(r_front) >= cnt) ? '0 : r_front;
        front0 = live_from(start0, live);

        is_idle  = !all_halted && (thr_ready == '0);
        is_skip  = !all_halted && !is_idle && (r_wait[front0] != '0);
        is_issue = !all_halted && !is_idle && !is_skip;

        succ_cnt = CW'(front0) + CW'(1);
        succ     = (succ_cnt == cnt) ? '0 : succ_cnt[TW-1:0];

        // blocked mode charges the penalty on a change of issuing thread;
        // pen1 folds in the ordinary decrement by one of the others
        pen_on = !r_policy && (front0 != r_last);
        pen1   = (pen_on ? {1'b0, r_switch_pen} : '0) + mis_pkg::ADD_W'(1);

        // per-thread lanes
        n_halted = r_halted;
        for (int t = 0; t < MAX_THREADS; t++) begin
            n_wait[t]    = r_wait[t];
            n_pc[t]      = r_pc[t];
            other_rdy[t] = 1'b0;
            if (is_idle && live[t] && (r_wait[t] != '0)) begin
                n_wait[t] = r_wait[t] - 1'b1;
            end
            if (is_issue) begin
                if (TW'(t) == front0) begin
                    n_pc[t] = r_pc[t] + 1'b1;
                    case (op)
                        mis_pkg::OP_LOAD:  n_wait[t] = r_load_lat;
                        mis_pkg::OP_STORE: n_wait[t] = r_store_lat;
                        mis_pkg::OP_HALT:  n_halted[t] = 1'b1;
                        default: ;
                    endcase
                end else if (live[t]) begin
                    n_wait[t]    = ({1'b0, r_wait[t]} > pen1)
                                   ? r_wait[t] - pen1[mis_pkg::LAT_W-1:0] : '0;
                    other_rdy[t] = (n_wait[t] == '0);
                end
            end
        end

        for (int t = 0; t < MAX_THREADS; t++) begin
            live_new[t] = in_range[t] && !n_halted[t];
        end

        rotate = r_policy || (op == mis_pkg::OP_HALT)
                 || (((op == mis_pkg::OP_LOAD) || (op == mis_pkg::OP_STORE))
                     && (other_rdy != '0));

        // one search serves both the skip and the rotate-after-issue case
        rot_mask  = is_issue ? live_new : live;
        rot_front = live_from(succ, rot_mask);

        if (is_skip || (is_issue && rotate)) begin
            n_front = rot_front;
        end else begin
            n_front = front0;
        end

        n_last = is_issue ? front0 : r_last;

        if (is_idle) begin
            added = mis_pkg::ADD_W'(1);
        end else if (is_issue) begin
            added = pen1;
        end else begin
            added = '0;
        end

        cyc_sum = {1'b0, r_cyc} + (mis_pkg::CYC_W+1)'(added);
        n_cyc   = cyc_sum[mis_pkg::CYC_W] ? mis_pkg::CYC_MAX : cyc_sum[mis_pkg::CYC_W-1:0];
        n_ins   = (is_issue && (r_ins != mis_pkg::INS_MAX)) ? r_ins + 1'b1 : r_ins;

        // counter of the new front, bumped if it is the thread that just issued
        next_pc = r_pc[n_front]
                  + {{(mis_pkg::PC_W-1){1'b0}}, (is_issue && (n_front == front0))};

        if (all_halted) begin
            act = mis_pkg::ACT_HALTED;
        end else if (is_idle) begin
            act = mis_pkg::ACT_IDLE;
        end else if (is_skip) begin
            act = mis_pkg::ACT_SKIP;
        end else begin
            act = mis_pkg::ACT_ISSUE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < MAX_THREADS; t++) begin
                r_wait[t] <= '0;
                r_pc[t]   <= '0;
            end
            r_halted <= '0;
            r_front  <= '0;
            r_last   <= '0;
            r_cyc    <= '0;
            r_ins    <= '0;
        end else if (step_go) begin
            for (int t = 0; t < MAX_THREADS; t++) begin
                r_wait[t] <= n_wait[t];
                r_pc[t]   <= n_pc[t];
            end
            r_halted <= n_halted;
            r_front  <= n_front;
            r_last   <= n_last;
            r_cyc    <= n_cyc;
            r_ins    <= n_ins;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    logic [mis_pkg::ACT_W-1:0]  r_out_action;
    logic [mis_pkg::TID_W-1:0]  r_out_issued;
    logic [mis_pkg::ADD_W-1:0]  r_out_added;
    logic [mis_pkg::CYC_W-1:0]  r_out_cyc;
    logic [mis_pkg::INS_W-1:0]  r_out_ins;
    logic [mis_pkg::TID_W-1:0]  r_out_next_thread;
    logic [mis_pkg::PC_W-1:0]   r_out_next_pc;

    always_ff @(posedge i_clk) begin
        if (step_go) begin
            r_out_action      <= act;
            r_out_issued      <= is_issue ? to_tid(front0) : '0;
            r_out_added       <= added;
            r_out_cyc         <= n_cyc;
            r_out_ins         <= n_ins;
            r_out_next_thread <= to_tid(n_front);
            r_out_next_pc     <= next_pc;
        end
    end

    assign o_result.valid              = r_out_valid;
    assign o_result.action             = r_out_action;
    assign o_result.issued_thread      = r_out_issued;
    assign o_result.cycles_added       = r_out_added;
    assign o_result.total_cycles       = r_out_cyc;
    assign o_result.total_instructions = r_out_ins;
    assign o_result.next_thread        = r_out_next_thread;
    assign o_result.next_pc            = r_out_next_pc;

endmodule

/* sim/mis_sched_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mis_sched_checker - scoreboard of the multithread issue scheduler
// Watches the step, result and APB channels, keeps its own copy of the
// scheduler state and registers, and checks every result transaction.
// ----------------------------------------------------------------------------
module mis_sched_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    mis_step_if                         step_mon,
    mis_result_if                       result_mon,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mis_pkg::APB_AW-1:0]  paddr,
    input  logic [mis_pkg::APB_DW-1:0]  pwdata,
    input  logic [mis_pkg::APB_DW-1:0]  prdata,
    input  logic                        pready,
    output int                          o_fail_count,
    output int                          o_pending
);

    localparam int THREADS = 8;

    typedef struct packed {
        mis_pkg::t_action           action;
        logic [mis_pkg::TID_W-1:0]  issued_thread;
        logic [mis_pkg::ADD_W-1:0]  cycles_added;
        logic [mis_pkg::CYC_W-1:0]  total_cycles;
        logic [mis_pkg::INS_W-1:0]  total_instructions;
        logic [mis_pkg::TID_W-1:0]  next_thread;
        logic [mis_pkg::PC_W-1:0]   next_pc;
    } t_step_outcome;

    // register copy
    logic                      cfg_policy;
    logic [mis_pkg::TC_W-1:0]  cfg_threads;
    logic [mis_pkg::LAT_W-1:0] cfg_load;
    logic [mis_pkg::LAT_W-1:0] cfg_store;
    logic [mis_pkg::LAT_W-1:0] cfg_pen;

    // scheduler state copy
    logic [mis_pkg::LAT_W-1:0]  wait_cnt [THREADS];
    logic [THREADS-1:0]         halt_mask;
    logic [mis_pkg::PC_W-1:0]   thread_pc [THREADS];
    int unsigned                front_tid;
    int unsigned                last_tid;
    logic [mis_pkg::CYC_W-1:0]  cyc_tot;
    logic [mis_pkg::INS_W-1:0]  ins_tot;

    t_step_outcome outcome_q [$];
    t_step_outcome outcome_nxt;
    t_step_outcome outcome_old;
    logic [mis_pkg::APB_DW-1:0] reg_expect;
    logic                       reg_mapped;
    int                         mismatches;

    // first live thread at or after start, cyclically; start if none
    function automatic int unsigned first_live(int unsigned start, int unsigned n);
        int unsigned k;
        int unsigned t;
        for (k = 0; k < n; k++) begin
            t = (start + k) % n;
            if (!halt_mask[t]) return t;
        end
        return start;
    endfunction

    task automatic predict_step(input mis_pkg::t_op op, output t_step_outcome res);
        int unsigned n;
        int unsigned t;
        int unsigned f;
        logic any_live;
        logic any_ready;
        logic other_ready;
        logic [mis_pkg::ADD_W-1:0] added;
        res         = '0;
        added       = '0;
        any_live    = 1'b0;
        any_ready   = 1'b0;
        other_ready = 1'b0;
        n = (cfg_threads == 0) ? 1 : (cfg_threads > THREADS) ? THREADS : cfg_threads;
        for (t = 0; t < n; t++) begin
            if (!halt_mask[t]) begin
                any_live = 1'b1;
                if (wait_cnt[t] == 0) any_ready = 1'b1;
            end
        end
        if (front_tid >= n) front_tid = 0;
        front_tid = first_live(front_tid, n);

        if (!any_live) begin
            res.action = mis_pkg::ACT_HALTED;
        end else if (!any_ready) begin
            // nobody ready: the core idles and every live counter ticks down
            for (t = 0; t < n; t++)
                if (!halt_mask[t] && wait_cnt[t] != 0) wait_cnt[t]--;
            added      = 1;
            res.action = mis_pkg::ACT_IDLE;
        end else if (wait_cnt[front_tid] != 0) begin
            front_tid  = first_live((front_tid + 1) % n, n);
            res.action = mis_pkg::ACT_SKIP;
        end else begin
            f = front_tid;
            if (!cfg_policy && f != last_tid) begin
                added = mis_pkg::ADD_W'(cfg_pen);
                for (t = 0; t < n; t++)
                    if (!halt_mask[t])
                        wait_cnt[t] = (wait_cnt[t] >= cfg_pen) ? wait_cnt[t] - cfg_pen : '0;
            end
            case (op)
                mis_pkg::OP_LOAD:  wait_cnt[f] = cfg_load;
                mis_pkg::OP_STORE: wait_cnt[f] = cfg_store;
                mis_pkg::OP_HALT:  halt_mask[f] = 1'b1;
                default: ;
            endcase
            thread_pc[f] = thread_pc[f] + 1'b1;
            last_tid     = f;
            added        = added + 1'b1;
            if (ins_tot != mis_pkg::INS_MAX) ins_tot = ins_tot + 1'b1;
            for (t = 0; t < n; t++) begin
                if (t != f && !halt_mask[t]) begin
                    if (wait_cnt[t] != 0) wait_cnt[t]--;
                    if (wait_cnt[t] == 0) other_ready = 1'b1;
                end
            end
            if (cfg_policy || op == mis_pkg::OP_HALT ||
                ((op == mis_pkg::OP_LOAD || op == mis_pkg::OP_STORE) && other_ready))
                front_tid = first_live((f + 1) % n, n);
            res.issued_thread = mis_pkg::TID_W'(f);
            res.action        = mis_pkg::ACT_ISSUE;
        end

        cyc_tot = (cyc_tot > mis_pkg::CYC_MAX - mis_pkg::CYC_W'(added))
                  ? mis_pkg::CYC_MAX : cyc_tot + mis_pkg::CYC_W'(added);
        if (front_tid >= n) front_tid = 0;
        front_tid = first_live(front_tid, n);

        res.cycles_added       = added;
        res.total_cycles       = cyc_tot;
        res.total_instructions = ins_tot;
        res.next_thread        = mis_pkg::TID_W'(front_tid);
        res.next_pc            = thread_pc[front_tid];
    endtask

    task automatic check_field(input string name, input logic [63:0] exp, input logic [63:0] got);
        if (exp !== got) begin
            $error("%s: expected %0d, got %0d", name, exp, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_policy  = mis_pkg::RST_POLICY;
            cfg_threads = mis_pkg::RST_THREAD_COUNT;
            cfg_load    = mis_pkg::RST_LOAD_LAT;
            cfg_store   = mis_pkg::RST_STORE_LAT;
            cfg_pen     = mis_pkg::RST_SWITCH_PEN;
            for (int t = 0; t < THREADS; t++) begin
                wait_cnt[t]  = '0;
                thread_pc[t] = '0;
            end
            halt_mask  = '0;
            front_tid  = 0;
            last_tid   = 0;
            cyc_tot    = '0;
            ins_tot    = '0;
            mismatches = 0;
            outcome_q.delete();
        end else begin
            // results first so a same-edge step never satisfies itself
            if (result_mon.valid && result_mon.ready) begin
                if (outcome_q.size() == 0) begin
                    $error("result transaction with no expectation waiting");
                    mismatches++;
                end else begin
                    outcome_old = outcome_q.pop_front();
                    check_field("action", outcome_old.action, result_mon.action);
                    check_field("issued_thread", outcome_old.issued_thread,
                                result_mon.issued_thread);
                    check_field("cycles_added", outcome_old.cycles_added,
                                result_mon.cycles_added);
                    check_field("total_cycles", outcome_old.total_cycles,
                                result_mon.total_cycles);
                    check_field("total_instructions", outcome_old.total_instructions,
                                result_mon.total_instructions);
                    check_field("next_thread", outcome_old.next_thread,
                                result_mon.next_thread);
                    check_field("next_pc", outcome_old.next_pc, result_mon.next_pc);
                end
            end
            if (step_mon.valid && step_mon.ready) begin
                predict_step(mis_pkg::t_op'(step_mon.op_kind), outcome_nxt);
                outcome_q.push_back(outcome_nxt);
            end
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (paddr[4:2])
                        mis_pkg::REG_POLICY:       cfg_policy  = pwdata[0];
                        mis_pkg::REG_THREAD_COUNT: cfg_threads = pwdata[mis_pkg::TC_W-1:0];
                        mis_pkg::REG_LOAD_LAT:     cfg_load    = pwdata[mis_pkg::LAT_W-1:0];
                        mis_pkg::REG_STORE_LAT:    cfg_store   = pwdata[mis_pkg::LAT_W-1:0];
                        mis_pkg::REG_SWITCH_PEN:   cfg_pen     = pwdata[mis_pkg::LAT_W-1:0];
                        default: ;
                    endcase
                end else begin
                    reg_mapped = 1'b1;
                    case (paddr[4:2])
                        mis_pkg::REG_POLICY:
                            reg_expect = mis_pkg::APB_DW'(cfg_policy);
                        mis_pkg::REG_THREAD_COUNT:
                            reg_expect = mis_pkg::APB_DW'(cfg_threads);
                        mis_pkg::REG_LOAD_LAT:
                            reg_expect = mis_pkg::APB_DW'(cfg_load);
                        mis_pkg::REG_STORE_LAT:
                            reg_expect = mis_pkg::APB_DW'(cfg_store);
                        mis_pkg::REG_SWITCH_PEN:
                            reg_expect = mis_pkg::APB_DW'(cfg_pen);
                        default: begin
                            reg_mapped = 1'b0;
                            reg_expect = '0;
                        end
                    endcase
                    if (reg_mapped) check_field("prdata", reg_expect, prdata);
                end
            end
        end
        o_fail_count = mismatches;
        o_pending    = outcome_q.size();
    end

endmodule

/* sim/multithread_issue_scheduler_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multithread_issue_scheduler_test - testbench of the issue scheduler
// Drives step transactions and APB register writes, stalls both channels in
// several patterns and leaves prediction and checking to the checker beside
// the block; prints the verdict once everything has drained.
// ----------------------------------------------------------------------------
module multithread_issue_scheduler_test;

    localparam int CYCLE_LIMIT = 400000;   // watchdog, far above a slow run
    localparam int LONG_HOLD   = 300;      // receiver hold-off, in cycles
    localparam int PHASE_STEPS = 100;      // random step transactions per phase

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // APB side
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [mis_pkg::APB_AW-1:0] paddr;
    logic [mis_pkg::APB_DW-1:0] pwdata;
    logic [mis_pkg::APB_DW-1:0] prdata;
    logic                       pready;

    mis_step_if   step_ch ();
    mis_result_if res_ch ();

    // channel pressure knobs, set per phase by the stimulus
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_asked     = 0;   // bumped by the stimulus to ask for a long hold-off
    int hold_done      = 0;

    int fail_count;
    int pending;
    int cycle_count;

    multithread_issue_scheduler #(
        .MAX_THREADS (8)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step_ch),
        .o_result (res_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    mis_sched_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .step_mon     (step_ch),
        .result_mon   (res_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: a run that never drains ends here.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("multithread_issue_scheduler_test: FAIL");
        $finish;
    end

    // Result sink. Ready changes only at the falling edge; a requested long
    // hold-off is counted here, independent of the sender.
    initial begin
        res_ch.ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (hold_asked != hold_done) begin
                hold_done++;
                res_ch.ready = 1'b0;
                for (int i = 1; i < LONG_HOLD; i++) @(negedge i_clk);
            end else begin
                res_ch.ready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // One step transaction. Called at a falling edge, returns at the falling
    // edge after acceptance; valid is written once per edge so back-to-back
    // transactions keep it high.
    task automatic send_step(input mis_pkg::t_op op);
        while ($urandom_range(99) < send_idle_pct) begin
            step_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        step_ch.valid   = 1'b1;
        step_ch.op_kind = op;
        @(posedge i_clk);
        while (!step_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // APB setup + access phases; pready is sampled at the rising edge.
    task automatic reg_access(input logic wr, input logic [mis_pkg::REG_IDX_W-1:0] idx,
                              input logic [mis_pkg::APB_DW-1:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = {idx, 2'b00};
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // write, then read back so the checker can compare prdata
    task automatic set_reg(input logic [mis_pkg::REG_IDX_W-1:0] idx,
                           input logic [mis_pkg::APB_DW-1:0] data);
        reg_access(1'b1, idx, data);
        reg_access(1'b0, idx, '0);
    endtask

    // Sender pauses until every expected result has come, plus a short margin
    // for the two pipeline registers.
    task automatic settle();
        step_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // 0 none, 1 sender idle, 2 receiver stalls, 3 both
    task automatic set_idle_mode(input int mode);
        case (mode)
            1:       begin send_idle_pct = 75; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 75; end
            3:       begin send_idle_pct = 34; recv_stall_pct = 34; end
            default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    // random instruction kinds; halt_pct sets how often a thread is retired
    task automatic send_ops(input int count, input int halt_pct);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < halt_pct)
                send_step(mis_pkg::OP_HALT);
            else if (r < halt_pct + (100 - halt_pct) / 2)
                send_step(mis_pkg::OP_OTHER);
            else if ($urandom_range(1))
                send_step(mis_pkg::OP_LOAD);
            else
                send_step(mis_pkg::OP_STORE);
        end
    endtask

    // mostly short latencies so few steps are spent idling; now and then
    // the full 8-bit range
    function automatic logic [mis_pkg::APB_DW-1:0] pick_latency();
        if ($urandom_range(7) == 0) return mis_pkg::APB_DW'($urandom_range(255));
        return mis_pkg::APB_DW'($urandom_range(10));
    endfunction

    task automatic random_config();
        logic [mis_pkg::APB_DW-1:0] tc;
        // counts of 0 and above eight are folded by the block; keep them rare
        if ($urandom_range(9) == 0)
            tc = ($urandom_range(1)) ? 32'd0 : mis_pkg::APB_DW'($urandom_range(9, 15));
        else
            tc = mis_pkg::APB_DW'($urandom_range(1, 8));
        set_reg(mis_pkg::REG_POLICY, mis_pkg::APB_DW'($urandom_range(1)));
        set_reg(mis_pkg::REG_THREAD_COUNT, tc);
        set_reg(mis_pkg::REG_LOAD_LAT, pick_latency());
        set_reg(mis_pkg::REG_STORE_LAT, pick_latency());
        set_reg(mis_pkg::REG_SWITCH_PEN, pick_latency());
    endtask

    initial begin
        step_ch.valid   = 1'b0;
        step_ch.op_kind = mis_pkg::OP_OTHER;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (2) @(negedge i_clk);

        // --- directed part ---
        // Reset settings, two threads blocked: thread 0 first issues free of
        // penalty, its load hands over to thread 1 which pays the switch.
        send_step(mis_pkg::OP_OTHER);
        send_step(mis_pkg::OP_LOAD);
        send_step(mis_pkg::OP_OTHER);
        send_step(mis_pkg::OP_STORE);
        send_step(mis_pkg::OP_OTHER);
        settle();

        // Count 0 folds to one thread; front beyond the count is pulled back
        // to thread 0, and its load leaves nobody ready so idle cycles follow.
        set_reg(mis_pkg::REG_THREAD_COUNT, 32'hFFFF_FFF0);
        set_reg(mis_pkg::REG_LOAD_LAT, 32'd3);
        send_step(mis_pkg::OP_LOAD);
        repeat (4) send_step(mis_pkg::OP_OTHER);
        settle();

        // Count 15 folds to eight, fine-grained rotation, longest latencies;
        // waiting fronts get skipped.
        set_reg(mis_pkg::REG_THREAD_COUNT, 32'd15);
        set_reg(mis_pkg::REG_POLICY, 32'hFFFF_FFFF);
        set_reg(mis_pkg::REG_LOAD_LAT, 32'd255);
        set_reg(mis_pkg::REG_STORE_LAT, 32'd255);
        send_step(mis_pkg::OP_STORE);
        send_step(mis_pkg::OP_LOAD);
        repeat (4) send_step(mis_pkg::OP_OTHER);
        settle();

        // Back to blocked mode mid-run with the largest penalty, which drains
        // the long waits in one switch.
        set_reg(mis_pkg::REG_POLICY, 32'd0);
        set_reg(mis_pkg::REG_SWITCH_PEN, 32'd255);
        send_step(mis_pkg::OP_OTHER);
        send_step(mis_pkg::OP_LOAD);
        send_step(mis_pkg::OP_OTHER);
        send_step(mis_pkg::OP_STORE);
        settle();

        // Zero penalty and zero latencies; an unmapped register write is
        // ignored.
        set_reg(mis_pkg::REG_SWITCH_PEN, 32'd0);
        set_reg(mis_pkg::REG_LOAD_LAT, 32'd0);
        set_reg(mis_pkg::REG_STORE_LAT, 32'd0);
        reg_access(1'b1, mis_pkg::REG_IDX_W'(6), 32'hFFFF_FFFF);
        send_step(mis_pkg::OP_LOAD);
        send_step(mis_pkg::OP_STORE);
        send_step(mis_pkg::OP_OTHER);
        settle();

        // --- random phases, no halts so threads stay live ---
        for (int phase = 0; phase < 8; phase++) begin
            random_config();
            set_idle_mode(phase % 4);
            // long sink hold-off while steps keep coming: the block backs up
            // and stalls its step channel
            if (phase == 0 || phase == 5) hold_asked++;
            send_ops(PHASE_STEPS, 0);
            settle();
        end

        // --- halt sweep: random halts retire threads ---
        set_idle_mode(3);
        set_reg(mis_pkg::REG_POLICY, 32'd0);
        set_reg(mis_pkg::REG_THREAD_COUNT, 32'd8);
        set_reg(mis_pkg::REG_LOAD_LAT, 32'd2);
        set_reg(mis_pkg::REG_STORE_LAT, 32'd1);
        set_reg(mis_pkg::REG_SWITCH_PEN, 32'd1);
        send_ops(60, 15);
        settle();
        set_reg(mis_pkg::REG_POLICY, 32'd1);
        send_ops(60, 15);
        settle();
        // shrink the count, possibly with the front now outside it
        set_reg(mis_pkg::REG_THREAD_COUNT, 32'd3);
        send_ops(6, 30);
        settle();
        set_reg(mis_pkg::REG_THREAD_COUNT, 32'd0);
        send_ops(4, 30);
        settle();

        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("multithread_issue_scheduler_test: PASS");
        end else begin
            $display("multithread_issue_scheduler_test: FAIL");
        end
        $finish;
    end

endmodule
